// File: sv/fsp_pkg.sv
// shared types, constants and helpers of the buffered flash program sequencer
package fsp_pkg;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 18;
  localparam int LIM_W   = 20;
  localparam int OFF_W   = 17;
  localparam int WORD_W  = 16;
  localparam int CMD_W   = 2;
  localparam int CIDX_W  = 2;
  localparam int CFG_W   = 32;

  localparam int DEF_BUFFER_WORDS     = 32;
  localparam int DEF_MAX_LENGTH_BYTES = 131072;
  localparam int DEF_QUEUE_DEPTH      = 4;

  localparam logic [ADDR_W-1:0] RST_BASE_ADDRESS  = 32'h0000_0000;
  localparam logic [LEN_W-1:0]  RST_LENGTH_BYTES  = 18'd64;
  localparam logic [LIM_W-1:0]  RST_TIMEOUT_LIMIT = 20'h50000;

  localparam logic [WORD_W-1:0] OP_CLEAR_STATUS = 16'h0050;
  localparam logic [WORD_W-1:0] OP_BUFFER_WRITE = 16'h00E8;
  localparam logic [WORD_W-1:0] OP_CONFIRM      = 16'h00D0;
  localparam logic [WORD_W-1:0] OP_READ_ARRAY   = 16'h00FF;
  localparam int                STATUS_READY_BIT = 7;

  localparam logic [CIDX_W-1:0] CFG_BASE_ADDRESS  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_LENGTH_BYTES  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_FLASH  = 2'd1,
    CMD_SOURCE = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FETCH = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OUTCOME_OK       = 2'd0,
    OUTCOME_TIMEOUT  = 2'd1,
    OUTCOME_MISMATCH = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POLL_SETUP,
    PH_DATA,
    PH_POLL_CONFIRM,
    PH_TIMEOUT_READ,
    PH_VERIFY_FLASH,
    PH_VERIFY_SOURCE
  } phase_t;

  // one entry per accepted item that has results
  typedef enum logic [3:0] {
    ACT_START_ZERO,
    ACT_START,
    ACT_SETUP_OK,
    ACT_CONF_NEXT,
    ACT_CONF_VERIFY,
    ACT_POLL,
    ACT_TIMEOUT_DONE,
    ACT_DATA_NEXT,
    ACT_DATA_LAST,
    ACT_VFETCH,
    ACT_MISMATCH,
    ACT_VNEXT,
    ACT_VDONE
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [ADDR_W-1:0] addr;
    logic [OFF_W-1:0]  idx;
    logic [WORD_W-1:0] data;
    logic [LEN_W-1:0]  detail;
  } fsp_rec_t;

  function automatic logic [1:0] rec_count(action_t a);
    logic [1:0] n;
    unique case (a)
      ACT_POLL, ACT_VFETCH, ACT_VNEXT:                               n = 2'd1;
      ACT_SETUP_OK, ACT_CONF_VERIFY, ACT_TIMEOUT_DONE, ACT_DATA_NEXT,
      ACT_MISMATCH, ACT_VDONE:                                       n = 2'd2;
      default:                                                       n = 2'd3;
    endcase
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] flash_at(logic [ADDR_W-1:0] base,
                                                 logic [OFF_W-1:0] off);
    return base + {{(ADDR_W-OFF_W-1){1'b0}}, off, 1'b0};
  endfunction

endpackage

// File: sv/fsp_front.sv
// front end: accepts input words, runs the command sequence, queues result entries
module fsp_front
  import fsp_pkg::*;
#(
  parameter int BUFFER_WORDS     = DEF_BUFFER_WORDS,
  parameter int MAX_LENGTH_BYTES = DEF_MAX_LENGTH_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [WORD_W-1:0] in_value,
  input  logic [ADDR_W-1:0] base_address,
  input  logic [LEN_W-1:0]  length_bytes,
  input  logic [LIM_W-1:0]  timeout_limit,
  input  logic              full,
  output logic              push,
  output fsp_rec_t          push_rec
);

  localparam int BI_W = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_LENGTH_BYTES);
  localparam logic [LEN_W-1:0]  BUF_BYTES = LEN_W'(2 * BUFFER_WORDS);
  localparam logic [BI_W-1:0]   LAST_IDX  = BI_W'(BUFFER_WORDS - 1);
  localparam logic [WORD_W-1:0] COUNT_OP  = WORD_W'(BUFFER_WORDS - 1);

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  program_remaining, program_remaining_next;
  logic [LIM_W-1:0]  poll_countdown, poll_countdown_next;
  logic [BI_W-1:0]   buffer_word_index, buffer_word_index_next;
  logic [OFF_W-1:0]  write_offset, write_offset_next;
  logic [LEN_W-1:0]  verify_remaining, verify_remaining_next;
  logic [OFF_W-1:0]  verify_offset, verify_offset_next;
  logic [WORD_W-1:0] held_flash_word, held_flash_word_next;

  logic             accept;
  logic [LEN_W-1:0] len_sat;
  logic [LIM_W-1:0] count_dec;
  logic [LEN_W-1:0] vr_dec;
  logic [OFF_W-1:0] vo_inc;

  assign in_ready  = !full;
  assign accept    = in_valid && !full;
  assign len_sat   = (length_bytes > MAX_LEN) ? MAX_LEN : length_bytes;
  assign count_dec = poll_countdown - LIM_W'(1);
  assign vr_dec    = (verify_remaining > LEN_W'(2)) ? verify_remaining - LEN_W'(2) : '0;
  assign vo_inc    = verify_offset + OFF_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      program_remaining <= '0;
      poll_countdown    <= '0;
      buffer_word_index <= '0;
      write_offset      <= '0;
      verify_remaining  <= '0;
      verify_offset     <= '0;
      held_flash_word   <= '0;
    end else begin
      phase             <= phase_next;
      program_remaining <= program_remaining_next;
      poll_countdown    <= poll_countdown_next;
      buffer_word_index <= buffer_word_index_next;
      write_offset      <= write_offset_next;
      verify_remaining  <= verify_remaining_next;
      verify_offset     <= verify_offset_next;
      held_flash_word   <= held_flash_word_next;
    end
  end

  always_comb begin
    phase_next             = phase;
    program_remaining_next = program_remaining;
    poll_countdown_next    = poll_countdown;
    buffer_word_index_next = buffer_word_index;
    write_offset_next      = write_offset;
    verify_remaining_next  = verify_remaining;
    verify_offset_next     = verify_offset;
    held_flash_word_next   = held_flash_word;
    push                   = 1'b0;
    push_rec               = '0;
    if (accept) begin
      unique case (phase)
        PH_IDLE: begin
          if (in_command == CMD_START) begin
            program_remaining_next = len_sat;
            verify_remaining_next  = len_sat;
            write_offset_next      = '0;
            verify_offset_next     = '0;
            buffer_word_index_next = '0;
            push                   = 1'b1;
            if (len_sat == '0) begin
              push_rec.action = ACT_START_ZERO;
            end else begin
              push_rec.action     = ACT_START;
              phase_next          = PH_POLL_SETUP;
              poll_countdown_next = timeout_limit;
            end
          end
        end
        PH_POLL_SETUP, PH_POLL_CONFIRM: begin
          if (in_command == CMD_FLASH) begin
            push = 1'b1;
            if (in_value[STATUS_READY_BIT]) begin
              if (phase == PH_POLL_SETUP) begin
                push_rec.action        = ACT_SETUP_OK;
                push_rec.data          = COUNT_OP;
                push_rec.idx           = write_offset;
                buffer_word_index_next = '0;
                phase_next             = PH_DATA;
              end else if (program_remaining != '0) begin
                push_rec.action     = ACT_CONF_NEXT;
                phase_next          = PH_POLL_SETUP;
                poll_countdown_next = timeout_limit;
              end else begin
                push_rec.action    = ACT_CONF_VERIFY;
                push_rec.addr      = flash_at(base_address, '0);
                verify_offset_next = '0;
                phase_next         = PH_VERIFY_FLASH;
              end
            end else begin
              poll_countdown_next = count_dec;
              push_rec.action     = ACT_POLL;
              if (count_dec == '0) begin
                push_rec.addr = flash_at(base_address, write_offset);
                phase_next    = PH_TIMEOUT_READ;
              end else begin
                push_rec.addr = base_address;
              end
            end
          end
        end
        PH_TIMEOUT_READ: begin
          if (in_command == CMD_FLASH) begin
            push            = 1'b1;
            push_rec.action = ACT_TIMEOUT_DONE;
            push_rec.detail = LEN_W'(in_value);
            phase_next      = PH_IDLE;
          end
        end
        PH_DATA: begin
          if (in_command == CMD_SOURCE) begin
            push                   = 1'b1;
            push_rec.addr          = flash_at(base_address, write_offset);
            push_rec.data          = in_value;
            push_rec.idx           = write_offset + OFF_W'(1);
            write_offset_next      = write_offset + OFF_W'(1);
            buffer_word_index_next = buffer_word_index + BI_W'(1);
            if (buffer_word_index == LAST_IDX) begin
              push_rec.action        = ACT_DATA_LAST;
              program_remaining_next = (program_remaining > BUF_BYTES) ?
                                       program_remaining - BUF_BYTES : '0;
              phase_next             = PH_POLL_CONFIRM;
              poll_countdown_next    = timeout_limit;
            end else begin
              push_rec.action = ACT_DATA_NEXT;
            end
          end
        end
        PH_VERIFY_FLASH: begin
          if (in_command == CMD_FLASH) begin
            push                 = 1'b1;
            push_rec.action      = ACT_VFETCH;
            push_rec.idx         = verify_offset;
            held_flash_word_next = in_value;
            phase_next           = PH_VERIFY_SOURCE;
          end
        end
        PH_VERIFY_SOURCE: begin
          if (in_command == CMD_SOURCE) begin
            push = 1'b1;
            if (held_flash_word != in_value) begin
              push_rec.action = ACT_MISMATCH;
              push_rec.detail = verify_remaining;
              phase_next      = PH_IDLE;
            end else begin
              verify_remaining_next = vr_dec;
              verify_offset_next    = vo_inc;
              if (vr_dec != '0) begin
                push_rec.action = ACT_VNEXT;
                push_rec.addr   = flash_at(base_address, vo_inc);
                phase_next      = PH_VERIFY_FLASH;
              end else begin
                push_rec.action = ACT_VDONE;
                phase_next      = PH_IDLE;
              end
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/fsp_queue.sv
// short queue of result entries between front and back
module fsp_queue
  import fsp_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fsp_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output fsp_rec_t q_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fsp_rec_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !q_valid))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// File: sv/fsp_back.sv
// back end: expands each queued entry into result words through an output register
module fsp_back
  import fsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  fsp_rec_t          q_rec,
  output logic              pop,
  input  logic [ADDR_W-1:0] base_address,
  output logic              m_valid,
  input  logic              m_ready,
  output kind_t             m_kind,
  output logic [ADDR_W-1:0] m_address,
  output logic [OFF_W-1:0]  m_source_index,
  output logic [WORD_W-1:0] m_data,
  output outcome_t          m_outcome,
  output logic [LEN_W-1:0]  m_detail,
  output logic              m_last
);

  logic [1:0]        step;
  logic              load;
  logic              last_step;
  kind_t             r_kind;
  logic [ADDR_W-1:0] r_address;
  logic [OFF_W-1:0]  r_index;
  logic [WORD_W-1:0] r_data;
  outcome_t          r_outcome;
  logic [LEN_W-1:0]  r_detail;

  assign last_step = (step == (rec_count(q_rec.action) - 2'd1));
  assign load      = q_valid && (!m_valid || m_ready);
  assign pop       = load && last_step;

  always_comb begin
    r_kind    = KIND_WRITE;
    r_address = base_address;
    r_index   = '0;
    r_data    = '0;
    r_outcome = OUTCOME_OK;
    r_detail  = '0;
    unique case (q_rec.action)
      ACT_START_ZERO, ACT_START: begin
        if (step == 2'd0) begin
          r_data = OP_CLEAR_STATUS;
        end else if (step == 2'd1) begin
          r_data = (q_rec.action == ACT_START) ? OP_BUFFER_WRITE : OP_READ_ARRAY;
        end else if (q_rec.action == ACT_START) begin
          r_kind = KIND_READ;
        end else begin
          r_kind    = KIND_DONE;
          r_address = '0;
        end
      end
      ACT_SETUP_OK, ACT_DATA_NEXT: begin
        if (step == 2'd0) begin
          r_data = q_rec.data;
          if (q_rec.action == ACT_DATA_NEXT) begin
            r_address = q_rec.addr;
          end
        end else begin
          r_kind    = KIND_FETCH;
          r_address = '0;
          r_index   = q_rec.idx;
        end
      end
      ACT_CONF_NEXT: begin
        if (step == 2'd0) begin
          r_data = OP_READ_ARRAY;
        end else if (step == 2'd1) begin
          r_data = OP_BUFFER_WRITE;
        end else begin
          r_kind = KIND_READ;
        end
      end
      ACT_CONF_VERIFY: begin
        if (step == 2'd0) begin
          r_data = OP_READ_ARRAY;
        end else begin
          r_kind    = KIND_READ;
          r_address = q_rec.addr;
        end
      end
      ACT_POLL, ACT_VNEXT: begin
        r_kind    = KIND_READ;
        r_address = q_rec.addr;
      end
      ACT_TIMEOUT_DONE, ACT_MISMATCH, ACT_VDONE: begin
        if (step == 2'd0) begin
          r_data = OP_READ_ARRAY;
        end else begin
          r_kind    = KIND_DONE;
          r_address = '0;
          r_detail  = q_rec.detail;
          if (q_rec.action == ACT_TIMEOUT_DONE) begin
            r_outcome = OUTCOME_TIMEOUT;
          end else if (q_rec.action == ACT_MISMATCH) begin
            r_outcome = OUTCOME_MISMATCH;
          end
        end
      end
      ACT_DATA_LAST: begin
        if (step == 2'd0) begin
          r_address = q_rec.addr;
          r_data    = q_rec.data;
        end else if (step == 2'd1) begin
          r_data = OP_CONFIRM;
        end else begin
          r_kind = KIND_READ;
        end
      end
      ACT_VFETCH: begin
        r_kind    = KIND_FETCH;
        r_address = '0;
        r_index   = q_rec.idx;
      end
      default: begin
        r_kind = KIND_WRITE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      step    <= '0;
    end else if (load) begin
      m_valid <= 1'b1;
      step    <= last_step ? 2'd0 : step + 2'd1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_kind         <= r_kind;
      m_address      <= r_address;
      m_source_index <= r_index;
      m_data         <= r_data;
      m_outcome      <= r_outcome;
      m_detail       <= r_detail;
      m_last         <= last_step;
    end
  end

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_valid && (m_kind == KIND_DONE) |-> m_last)
    else $error("finish word not marked last");
  a_mid_entry_held: assert property (@(posedge clk) disable iff (rst)
    (step != 2'd0) |-> q_valid)
    else $error("entry left the queue before all its words went out");
  a_done_no_address: assert property (@(posedge clk) disable iff (rst)
    m_valid && (m_kind == KIND_DONE) |-> (m_address == '0))
    else $error("finish word carries an address");

endmodule

// File: sv/flash_buffered_program_sequencer.sv
// top level: configuration registers, front end, entry queue and back end
// an input word's entry is registered in the queue, and its result words then pass the back end's output register
// throughput: one input word per cycle while the four-entry queue has room
// the back end sends one result word per cycle while m_axis_tready is high, one to three words per queued entry
// the queue between front and back sets how long the output side may stall
// reset: synchronous rst clears the sequence state and queue, registers take defaults
module flash_buffered_program_sequencer
  import fsp_pkg::*;
#(
  parameter int BUFFER_WORDS     = DEF_BUFFER_WORDS,
  parameter int MAX_LENGTH_BYTES = DEF_MAX_LENGTH_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // value
  input  logic [1:0]        s_axis_tuser,   // command
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [87:0]       m_axis_tdata,   // address, source_index, data, outcome, detail
  output logic [1:0]        m_axis_tuser,   // kind
  output logic              m_axis_tlast,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [ADDR_W-1:0] base_address;
  logic [LEN_W-1:0]  length_bytes;
  logic [LIM_W-1:0]  timeout_limit;

  logic              push, full, pop, q_valid;
  fsp_rec_t          push_rec, q_rec;
  kind_t             m_kind;
  outcome_t          m_outcome;
  logic [ADDR_W-1:0] m_address;
  logic [OFF_W-1:0]  m_source_index;
  logic [WORD_W-1:0] m_data;
  logic [LEN_W-1:0]  m_detail;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= RST_BASE_ADDRESS;
      length_bytes  <= RST_LENGTH_BYTES;
      timeout_limit <= RST_TIMEOUT_LIMIT;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_ADDRESS) begin
        base_address <= cfg_data;
      end else if (cfg_index == CFG_LENGTH_BYTES) begin
        length_bytes <= cfg_data[LEN_W-1:0];
      end else if (cfg_index == CFG_TIMEOUT_LIMIT) begin
        timeout_limit <= cfg_data[LIM_W-1:0];
      end
    end
  end

  fsp_front #(
    .BUFFER_WORDS    (BUFFER_WORDS),
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_command   (s_axis_tuser),
    .in_value     (s_axis_tdata),
    .base_address (base_address),
    .length_bytes (length_bytes),
    .timeout_limit(timeout_limit),
    .full         (full),
    .push         (push),
    .push_rec     (push_rec)
  );

  fsp_queue #(
    .DEPTH(DEF_QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .full    (full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_rec   (q_rec)
  );

  fsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_rec         (q_rec),
    .pop           (pop),
    .base_address  (base_address),
    .m_valid       (m_axis_tvalid),
    .m_ready       (m_axis_tready),
    .m_kind        (m_kind),
    .m_address     (m_address),
    .m_source_index(m_source_index),
    .m_data        (m_data),
    .m_outcome     (m_outcome),
    .m_detail      (m_detail),
    .m_last        (m_axis_tlast)
  );

  assign m_axis_tuser = m_kind;
  assign m_axis_tdata = {3'b000, m_detail, m_outcome, m_data, m_source_index, m_address};

endmodule
